/* hw/rtl/i2cmbe_pkg.sv */
// Shared types and codes for the I2C master bit engine.
// No dependencies; imported by i2cmbe_seq and i2c_master_bit_engine.
package i2cmbe_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_ADDR  = 3'd5;

    localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] CFG_STRETCH     = 2'd1;
    localparam logic [1:0] CFG_BIT_ORDER   = 2'd2;
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd3;

    localparam logic [7:0]  GEN_CALL_CFG = 8'hFF;
    localparam logic [7:0]  RD_BIT_LSB   = 8'h80;
    localparam logic [7:0]  RD_BIT_MSB   = 8'h01;

    typedef struct packed {
        logic [9:0]  half_period_ticks;
        logic [15:0] stretch_timeout;
        logic        lsb_mode;
        logic [15:0] device_address;
    } t_cfg;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic       read_not_write;
        logic       scl_level;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       nack;
        logic [7:0] rx_data;
        logic       rejected;
    } t_res;

endpackage

/* hw/rtl/i2cmbe_seq.sv */
// Bit sequencer of the I2C master engine: state registers and one-step logic.
// Depends on i2cmbe_pkg for the item, result and configuration structs.
module i2cmbe_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  i2cmbe_pkg::t_item i_item,
    input  i2cmbe_pkg::t_cfg  i_cfg,
    output i2cmbe_pkg::t_res  o_res
);
    import i2cmbe_pkg::*;

    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000000000000001,
        PH_ST_SCL    = 15'b000000000000010,
        PH_ST_END    = 15'b000000000000100,
        PH_SP_SDA    = 15'b000000000001000,
        PH_SP_W1     = 15'b000000000010000,
        PH_SP_W2     = 15'b000000000100000,
        PH_WB_HIGH   = 15'b000000001000000,
        PH_WB_LOW    = 15'b000000010000000,
        PH_RB_HIGH   = 15'b000000100000000,
        PH_RB_LOW    = 15'b000001000000000,
        PH_AK_HIGH   = 15'b000010000000000,
        PH_AK_POLL   = 15'b000100000000000,
        PH_AK_REPOLL = 15'b001000000000000,
        PH_AK_SAMPLE = 15'b010000000000000,
        PH_AK_END    = 15'b100000000000000
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [2:0]  r_cmd,     n_cmd;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift,   n_shift;
    logic [9:0]  r_wait,    n_wait;
    logic [15:0] r_stretch, n_stretch;
    logic        r_pend,    n_pend;
    logic        r_scl,     n_scl;
    logic        r_sda,     n_sda;
    logic        r_nack,    n_nack;
    logic [7:0]  r_rdata,   n_rdata;

    logic [9:0]  half;
    logic        is_cmd;
    logic        do_write;
    logic [7:0]  wr_byte;
    logic        do_ack;
    logic        do_finish;
    logic        rej;
    logic [7:0]  shifted;
    logic [3:0]  bit_inc;
    logic [15:0] dev_addr;

    assign half     = (i_cfg.half_period_ticks == '0) ? 10'd1 : i_cfg.half_period_ticks;
    assign is_cmd   = (i_item.opcode >= OP_START) && (i_item.opcode <= OP_ADDR);
    assign shifted  = i_cfg.lsb_mode ? {1'b0, r_shift[7:1]} : {r_shift[6:0], 1'b0};
    assign bit_inc  = r_bit_cnt + 4'd1;
    assign dev_addr = (i_cfg.device_address == {8'h00, GEN_CALL_CFG}) ? 16'h0000
                                                                      : i_cfg.device_address;

    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_stretch = r_stretch;
        n_pend    = r_pend;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_nack    = r_nack;
        n_rdata   = r_rdata;
        do_write  = 1'b0;
        wr_byte   = r_shift;
        do_ack    = 1'b0;
        do_finish = 1'b0;
        rej       = 1'b0;

        if (r_phase != PH_IDLE) begin
            rej = is_cmd;
            if (r_wait > 10'd1) begin
                n_wait = r_wait - 10'd1;
            end else begin
                unique case (r_phase)
                    PH_ST_SCL: begin
                        n_scl   = 1'b1;
                        n_phase = PH_ST_END;
                        n_wait  = half;
                    end
                    PH_SP_SDA: begin
                        n_sda   = 1'b0;
                        n_phase = PH_SP_W1;
                        n_wait  = half;
                    end
                    PH_SP_W1: begin
                        n_phase = PH_SP_W2;
                        n_wait  = half;
                    end
                    PH_WB_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_WB_LOW;
                        n_wait  = half;
                    end
                    PH_WB_LOW: begin
                        n_scl     = 1'b1;
                        n_shift   = shifted;
                        n_bit_cnt = bit_inc;
                        if (bit_inc < 4'd8) begin
                            n_sda   = i_cfg.lsb_mode ? ~shifted[0] : ~shifted[7];
                            n_phase = PH_WB_HIGH;
                            n_wait  = half;
                        end else begin
                            do_ack = 1'b1;
                        end
                    end
                    PH_RB_HIGH: begin
                        if (i_item.sda_level) begin
                            n_shift = r_shift | (i_cfg.lsb_mode ? RD_BIT_LSB
                                                                : RD_BIT_MSB);
                        end
                        n_scl     = 1'b1;
                        n_bit_cnt = bit_inc;
                        n_phase   = PH_RB_LOW;
                        n_wait    = half;
                    end
                    PH_RB_LOW: begin
                        if (r_bit_cnt < 4'd8) begin
                            n_shift = shifted;
                            n_scl   = 1'b0;
                            n_phase = PH_RB_HIGH;
                            n_wait  = half;
                        end else begin
                            do_ack = 1'b1;
                        end
                    end
                    PH_AK_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_AK_POLL;
                        n_wait  = half;
                    end
                    PH_AK_POLL, PH_AK_REPOLL: begin
                        n_wait = 10'd1;
                        if (!i_item.scl_level && (r_stretch != '0)) begin
                            n_stretch = r_stretch - 16'd1;
                            n_phase   = PH_AK_REPOLL;
                        end else begin
                            n_phase = PH_AK_SAMPLE;
                        end
                    end
                    PH_AK_SAMPLE: begin
                        n_nack  = i_item.sda_level;
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = PH_AK_END;
                        n_wait  = half;
                    end
                    PH_AK_END: begin
                        n_pend = 1'b0;
                        if ((r_cmd == OP_ADDR) && r_pend && !r_nack) begin
                            do_write = 1'b1;
                            wr_byte  = dev_addr[7:0];
                        end else begin
                            if (r_cmd == OP_READ) begin
                                n_rdata = r_shift;
                            end
                            do_finish = 1'b1;
                        end
                    end
                    default: begin
                        do_finish = 1'b1;
                    end
                endcase
            end
        end else if (is_cmd) begin
            n_cmd = i_item.opcode;
            unique case (i_item.opcode)
                OP_START: begin
                    n_sda   = 1'b1;
                    n_phase = PH_ST_SCL;
                    n_wait  = half;
                end
                OP_STOP: begin
                    n_scl   = 1'b0;
                    n_phase = PH_SP_SDA;
                    n_wait  = half;
                end
                OP_WRITE: begin
                    n_pend   = 1'b0;
                    do_write = 1'b1;
                    wr_byte  = i_item.data_byte;
                end
                OP_READ: begin
                    n_pend    = 1'b0;
                    n_shift   = '0;
                    n_bit_cnt = '0;
                    n_sda     = 1'b0;
                    n_scl     = 1'b0;
                    n_phase   = PH_RB_HIGH;
                    n_wait    = half;
                end
                default: begin
                    do_write = 1'b1;
                    if (dev_addr > 16'h00FF) begin
                        n_pend  = 1'b1;
                        wr_byte = {dev_addr[14:8], i_item.read_not_write};
                    end else begin
                        n_pend  = 1'b0;
                        wr_byte = {dev_addr[6:0], i_item.read_not_write};
                    end
                end
            endcase
        end

        if (do_write) begin
            n_shift   = wr_byte;
            n_bit_cnt = '0;
            n_scl     = 1'b1;
            n_sda     = i_cfg.lsb_mode ? ~wr_byte[0] : ~wr_byte[7];
            n_phase   = PH_WB_HIGH;
            n_wait    = half;
        end
        if (do_ack) begin
            n_scl     = 1'b1;
            n_sda     = 1'b0;
            n_stretch = i_cfg.stretch_timeout;
            n_phase   = PH_AK_HIGH;
            n_wait    = half;
        end
        if (do_finish) begin
            n_phase = PH_IDLE;
            n_wait  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= OP_TICK;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_stretch <= '0;
            r_pend    <= 1'b0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
            r_nack    <= 1'b0;
            r_rdata   <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_stretch <= n_stretch;
            r_pend    <= n_pend;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_nack    <= n_nack;
            r_rdata   <= n_rdata;
        end
    end

    assign o_res.scl_pull_low = n_scl;
    assign o_res.sda_pull_low = n_sda;
    assign o_res.busy_res     = (n_phase != PH_IDLE);
    assign o_res.done_res     = do_finish;
    assign o_res.nack         = n_nack;
    assign o_res.rx_data      = n_rdata;
    assign o_res.rejected     = rej;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && do_finish |=> (r_phase == PH_IDLE))
        else $error("sequence finished but engine not idle");

    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == '0))
        else $error("wait count left over while idle");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'd8)
        else $error("bit counter past one byte");

    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && rej |-> (r_phase != PH_IDLE) && is_cmd)
        else $error("command rejected while idle");

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: input word register, configuration
// registers and result register around i2cmbe_seq. Depends on i2cmbe_pkg.
//
//  channel | direction | handshake                | payload
//  in      | sink      | i_in_valid / o_in_ready   | opcode, data_byte, rnw, scl, sda
//  out     | source    | o_out_valid / i_out_ready | pins, busy, done, nack, data, rej
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word per clock while the output is not stalled: a word is held in the
// input register, the sequencer takes one step on it and the result lands in
// the output register, which raises result valid.
// Reset is synchronous; it releases the sequencer's lines and loads default config.
// A stalled output holds the pipe; the input register refills as it drains.
module i2c_master_bit_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_read_not_write,
    input  logic        i_scl_level,
    input  logic        i_sda_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_scl_pull_low,
    output logic        o_sda_pull_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_nack,
    output logic [7:0]  o_rx_data,
    output logic        o_rejected,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import i2cmbe_pkg::*;

    t_cfg  r_cfg;
    t_item r_item;
    logic  r_in_vld;
    t_res  r_res;
    logic  r_out_vld;
    t_res  step_res;
    logic  adv;

    assign adv         = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= 10'd5;
            r_cfg.stretch_timeout   <= '0;
            r_cfg.lsb_mode          <= 1'b0;
            r_cfg.device_address    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data[9:0];
                CFG_STRETCH:     r_cfg.stretch_timeout   <= i_cfg_data;
                CFG_BIT_ORDER:   r_cfg.lsb_mode          <= i_cfg_data[0];
                CFG_DEV_ADDR:    r_cfg.device_address    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.opcode         <= i_opcode;
            r_item.data_byte      <= i_data_byte;
            r_item.read_not_write <= i_read_not_write;
            r_item.scl_level      <= i_scl_level;
            r_item.sda_level      <= i_sda_level;
        end
    end

    i2cmbe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_scl_pull_low = r_res.scl_pull_low;
    assign o_sda_pull_low = r_res.sda_pull_low;
    assign o_busy_res     = r_res.busy_res;
    assign o_done_res     = r_res.done_res;
    assign o_nack         = r_res.nack;
    assign o_rx_data      = r_res.rx_data;
    assign o_rejected     = r_res.rejected;

endmodule
